// ===== design/pli_pkg.sv =====
package pli_pkg;

  // table geometry
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int STEP_W     = $clog2(PROD_W);
  localparam int SUM_W      = DATA_W + 3;

  // saturation bounds on the widened sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_FULL       = 2'd1,
    STS_NOT_RISING = 2'd2,
    STS_TOO_FEW    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_APND_CK,
    S_SCAN,
    S_CLAMP,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

endpackage

// ===== design/piecewise_linear_interpolator.sv =====
// piecewise linear interpolator over a table of signed Q16.16 breakpoints
//
// input channel s_axis: tuser carries the opcode (append, query, clear), tdata
// carries x_value and y_value. output channel m_axis: one beat per input beat,
// tdata carries interp_value, tuser carries status.
//
// appends must come with strictly rising x; a clear empties the table. a query
// uses the segment starting at the last breakpoint below x (clamped to the
// first and last segments) and returns the exact interpolated value, quotient
// truncated toward zero, saturated to 32 bits.
//
// clear, the unused opcode, status-only queries and appends to an empty or full
// table go straight to the output load; other appends first check x against the
// last point, and a full query runs a linear scan over the single read port and
// the 64-step restoring divider. one item is in work at a time; s_axis_tready_o
// is high only while the sequencer is idle.
//
// reset empties the table (breakpoint memories are not cleared, only the
// point count). a stalled receiver holds the result in the output register;
// the next beat is taken meanwhile but its result waits until the slot frees.
module piecewise_linear_interpolator
  import pli_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // x_value [31:0], y_value [63:32]
  input  logic [1:0]  s_axis_tuser_i,  // opcode [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // interp_value [31:0]
  output logic [1:0]  m_axis_tuser_o   // status [1:0]
);

  // breakpoint memories
  logic [DATA_W-1:0] break_x [MAX_POINTS];
  logic [DATA_W-1:0] break_y [MAX_POINTS];

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  seg_q, seg_d;
  logic [STEP_W-1:0] step_q, step_d;
  opcode_e           op_q, op_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0] y_q, y_d;
  logic [DATA_W-1:0] x0_q, x0_d;
  logic [DATA_W-1:0] y0_q, y0_d;
  logic [DATA_W-1:0] x1_q, x1_d;
  logic [DATA_W-1:0] y1_q, y1_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] dx_q, dx_d;
  logic              neg_q, neg_d;
  logic [PROD_W-1:0] dvd_q, dvd_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] res_val_q, res_val_d;
  status_e           res_sts_q, res_sts_d;

  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q, m_data_d;
  logic [1:0]        m_user_q, m_user_d;

  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_x_q, rd_y_q;
  logic              wr_en;

  // datapath temporaries
  logic signed [DATA_W:0] run_s, dy_s, dx_s;
  logic [DATA_W:0]        rem_shift;
  logic [DATA_W:0]        rem_sub;
  logic [SUM_W-1:0]       sum;
  logic                   quot_big;
  logic                   lt;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      break_x[count_q[IDX_W-1:0]] <= x_q;
      break_y[count_q[IDX_W-1:0]] <= y_q;
    end
    rd_x_q <= break_x[rd_addr];
    rd_y_q <= break_y[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    seg_q     <= seg_d;
    step_q    <= step_d;
    op_q      <= op_d;
    x_q       <= x_d;
    y_q       <= y_d;
    x0_q      <= x0_d;
    y0_q      <= y0_d;
    x1_q      <= x1_d;
    y1_q      <= y1_d;
    a_q       <= a_d;
    b_q       <= b_d;
    dx_q      <= dx_d;
    neg_q     <= neg_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    res_val_q <= res_val_d;
    res_sts_q <= res_sts_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  // shared arithmetic
  assign run_s     = $signed({x_q[DATA_W-1], x_q}) - $signed({x0_q[DATA_W-1], x0_q});
  assign dy_s      = $signed({y1_q[DATA_W-1], y1_q}) - $signed({y0_q[DATA_W-1], y0_q});
  assign dx_s      = $signed({x1_q[DATA_W-1], x1_q}) - $signed({x0_q[DATA_W-1], x0_q});
  assign rem_shift = {rem_q, dvd_q[PROD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dx_q};
  assign quot_big  = (|dvd_q[PROD_W-1:DATA_W+2]) ||
                     (dvd_q[DATA_W+1] && (|dvd_q[DATA_W:0]));
  assign sum       = neg_q ? ({{3{y0_q[DATA_W-1]}}, y0_q} - {1'b0, dvd_q[DATA_W+1:0]})
                           : ({{3{y0_q[DATA_W-1]}}, y0_q} + {1'b0, dvd_q[DATA_W+1:0]});
  assign lt        = $signed(rd_x_q) < $signed(x_q);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cnt_d     = cnt_q;
    seg_d     = seg_q;
    step_d    = step_q;
    op_d      = op_q;
    x_d       = x_q;
    y_d       = y_q;
    x0_d      = x0_q;
    y0_d      = y0_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    a_d       = a_q;
    b_d       = b_q;
    dx_d      = dx_q;
    neg_d     = neg_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    res_val_d = res_val_q;
    res_sts_d = res_sts_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    rd_addr   = count_q[IDX_W-1:0] - IDX_W'(1);
    wr_en     = 1'b0;

    // output slot drains on a taken beat
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d      = opcode_e'(s_axis_tuser_i);
          x_d       = s_axis_tdata_i[31:0];
          y_d       = s_axis_tdata_i[63:32];
          res_val_d = '0;
          res_sts_d = STS_OK;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_APPEND: begin
            if (count_q >= CNT_W'(MAX_POINTS)) begin
              res_sts_d = STS_FULL;
            end else if (count_q == '0) begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end else begin
              state_d = S_APND_CK;
            end
          end
          OP_QUERY: begin
            if (count_q < CNT_W'(2)) begin
              res_sts_d = STS_TOO_FEW;
            end else begin
              cnt_d   = '0;
              seg_d   = '0;
              state_d = S_SCAN;
            end
          end
          OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_APND_CK: begin
        if ($signed(x_q) <= $signed(rd_x_q)) begin
          res_sts_d = STS_NOT_RISING;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end
      // linear scan, read data is registered so it lags the address
      S_SCAN: begin
        rd_addr = cnt_q[IDX_W-1:0];
        if (cnt_q != '0 && lt) begin
          seg_d = cnt_q[IDX_W-1:0] - IDX_W'(1);
        end
        if ((cnt_q != '0 && !lt) || cnt_q == count_q) begin
          state_d = S_CLAMP;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_CLAMP: begin
        if ({1'b0, seg_q} >= count_q - CNT_W'(1)) begin
          seg_d = count_q[IDX_W-1:0] - IDX_W'(2);
        end
        state_d = S_FETCH0;
      end
      S_FETCH0: begin
        rd_addr = seg_q;
        state_d = S_FETCH1;
      end
      S_FETCH1: begin
        rd_addr = seg_q + IDX_W'(1);
        x0_d    = rd_x_q;
        y0_d    = rd_y_q;
        state_d = S_FETCH2;
      end
      S_FETCH2: begin
        x1_d    = rd_x_q;
        y1_d    = rd_y_q;
        state_d = S_DIFF;
      end
      // magnitudes and sign of the product
      S_DIFF: begin
        neg_d   = run_s[DATA_W] ^ dy_s[DATA_W];
        a_d     = run_s[DATA_W] ? DATA_W'(-run_s) : run_s[DATA_W-1:0];
        b_d     = dy_s[DATA_W] ? DATA_W'(-dy_s) : dy_s[DATA_W-1:0];
        dx_d    = dx_s[DATA_W-1:0];
        state_d = S_MUL;
      end
      S_MUL: begin
        dvd_d   = PROD_W'(a_q) * PROD_W'(b_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (!rem_sub[DATA_W]) begin
          rem_d = rem_sub[DATA_W-1:0];
          dvd_d = {dvd_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[DATA_W-1:0];
          dvd_d = {dvd_q[PROD_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(PROD_W - 1)) begin
          state_d = S_FIN;
        end
      end
      // add to base and saturate
      S_FIN: begin
        if (quot_big) begin
          res_val_d = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if ($signed(sum) > SUM_MAX) begin
          res_val_d = 32'h7FFF_FFFF;
        end else if ($signed(sum) < SUM_MIN) begin
          res_val_d = 32'h8000_0000;
        end else begin
          res_val_d = sum[DATA_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = res_val_q;
          m_user_d  = res_sts_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/piecewise_linear_interpolator_tb.sv =====
module piecewise_linear_interpolator_tb
  import pli_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode 3 is not decoded by the block, it must pass as a no-op
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam int ITEM_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 600;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  sts;
  } interp_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] xv;
    logic [31:0] yv;
    logic        fixed;
    interp_res_t want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // stimulus side
  logic        s_valid     = 1'b0;
  logic [1:0]  s_op        = OP_APPEND;
  logic [31:0] s_x         = '0;
  logic [31:0] s_y         = '0;
  logic        s_fixed     = 1'b0;
  interp_res_t s_fixed_res = '0;
  logic        s_ready;

  // result side
  logic        m_ready = 1'b0;
  logic        m_valid;
  logic [31:0] m_data;
  logic [1:0]  m_user;

  // breakpoint table as the block should hold it
  logic signed [31:0] bp_x [MAX_POINTS];
  logic signed [31:0] bp_y [MAX_POINTS];
  int unsigned        bp_count = 0;

  interp_res_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt  = 0;
  logic        tx_burst   = 1'b0;
  logic        rx_burst   = 1'b0;

  dir_row_t dir_rows [25];

  piecewise_linear_interpolator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  ({s_y, s_x}),  // x_value [31:0], y_value [63:32]
    .s_axis_tuser_i  (s_op),        // opcode [1:0]
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),      // interp_value [31:0]
    .m_axis_tuser_o  (m_user)       // status [1:0]
  );

  always #4 clk_i = ~clk_i;

  // exact interpolation on the current table, saturated to 32 bits
  function automatic logic signed [31:0] interp_at(input logic signed [31:0] xq);
    int unsigned seg;
    int unsigned i;
    longint      run, dy, dx, base, total;
    logic [63:0] mag_run, mag_dy, mag_prod, dx_u, quot;
    logic        neg;
    seg = 0;
    for (i = 0; i < bp_count; i++) begin
      if (bp_x[i] < xq) seg = i;
    end
    if (seg >= bp_count - 1) seg = bp_count - 2;
    run  = longint'(xq) - longint'(bp_x[seg]);
    dy   = longint'(bp_y[seg+1]) - longint'(bp_y[seg]);
    dx   = longint'(bp_x[seg+1]) - longint'(bp_x[seg]);
    neg  = (run < 0) != (dy < 0);
    mag_run  = (run < 0) ? -run : run;
    mag_dy   = (dy < 0) ? -dy : dy;
    mag_prod = mag_run * mag_dy;
    dx_u     = dx;
    quot     = mag_prod / dx_u;
    base     = longint'(bp_y[seg]);
    if (quot > 64'h2_0000_0000) return neg ? Q_MIN : Q_MAX;
    total = neg ? base - longint'(quot) : base + longint'(quot);
    if (total > longint'(Q_MAX)) return Q_MAX;
    if (total < longint'(Q_MIN)) return Q_MIN;
    return total[31:0];
  endfunction

  // apply one beat to the table and return the result it must produce
  function automatic interp_res_t table_apply(input logic [1:0] op,
                                              input logic signed [31:0] xv,
                                              input logic signed [31:0] yv);
    interp_res_t r;
    r     = '0;
    r.sts = STS_OK;
    case (op)
      OP_APPEND: begin
        if (bp_count >= MAX_POINTS) begin
          r.sts = STS_FULL;
        end else if (bp_count > 0 && xv <= bp_x[bp_count-1]) begin
          r.sts = STS_NOT_RISING;
        end else begin
          bp_x[bp_count] = xv;
          bp_y[bp_count] = yv;
          bp_count++;
        end
      end
      OP_QUERY: begin
        if (bp_count < 2) r.sts = STS_TOO_FEW;
        else r.value = interp_at(xv);
      end
      OP_CLEAR: bp_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] clip_q(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %0s at cycle %0d: expected %h, got %h",
               field, cycle_cnt, want, got);
  endtask

  // check result beats against the oldest expectation, then record new input beats
  always @(posedge clk_i) begin
    interp_res_t want;
    interp_res_t pred;
    if (m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result beat", '0, m_data);
      end else begin
        want = pending_results.pop_front();
        if (m_data !== want.value) flag_mismatch("interp_value", want.value, m_data);
        if (m_user !== want.sts) flag_mismatch("status", 32'(want.sts), 32'(m_user));
      end
    end
    if (s_valid && s_ready) begin
      pred = table_apply(s_op, s_x, s_y);
      pending_results.insert(pending_results.size(), s_fixed ? s_fixed_res : pred);
    end
  end

  // offer one beat after a random gap and hold it until taken
  task automatic send_item(input logic [1:0] op, input logic [31:0] xv,
                           input logic [31:0] yv, input logic fixed,
                           input interp_res_t want);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid     <= 1'b1;
    s_op        <= op;
    s_x         <= xv;
    s_y         <= yv;
    s_fixed     <= fixed;
    s_fixed_res <= want;
    do @(posedge clk_i); while (!s_ready);
    items_sent++;
  endtask

  // one load of rising breakpoints with noise mixed in, then a burst of queries
  task automatic load_and_query(input bit fill);
    longint      xs [$];
    longint      step_max, lim, xnext, span, lo, hi;
    int unsigned npts, nq, shape, ymode, pick, k;
    logic [31:0] ycur, yv, xq;
    if (fill || $urandom_range(0, 6) != 0)
      send_item(OP_CLEAR, $urandom, $urandom, 1'b0, '0);
    shape = fill ? 0 : $urandom_range(0, 11);
    if (shape == 0) npts = MAX_POINTS + $urandom_range(1, 3);
    else if (shape == 1) npts = $urandom_range(0, 1);
    else if (shape == 2) npts = $urandom_range(9, 40);
    else npts = $urandom_range(2, 8);
    case ($urandom_range(0, 3))
      0: step_max = 16;
      1: step_max = 64'd1 << 17;
      2: step_max = 64'd1 << 26;
      default: step_max = 64'hFFFF_FFFF / (npts + 1);
    endcase
    if (npts > 40) step_max = (64'hFFFF_FFFF / (npts + 1)) >> $urandom_range(0, 12);
    if (step_max < 1) step_max = 1;
    lim = 64'hFFFF_FFFF - longint'(npts) * step_max;
    if (lim < 0) lim = 0;
    xnext = longint'(Q_MIN) + longint'($urandom_range(0, 32'(lim)));
    ymode = $urandom_range(0, 2);
    ycur  = $urandom;
    for (k = 0; k < npts; k++) begin
      // noise: non-rising append, unused opcode, early query
      if (xs.size() > 0 && $urandom_range(0, 9) == 0)
        send_item(OP_APPEND, clip_q(xs[$] - longint'($urandom_range(0, 3))), $urandom,
                  1'b0, '0);
      if ($urandom_range(0, 29) == 0) send_item(OP_NOP, $urandom, $urandom, 1'b0, '0);
      if ($urandom_range(0, 19) == 0) send_item(OP_QUERY, $urandom, $urandom, 1'b0, '0);
      if (xnext > longint'(Q_MAX)) break;
      case (ymode)
        0: yv = $urandom;
        1: begin
          ycur = ycur + $urandom_range(0, 32'h2_0000) - 32'h1_0000;
          yv   = ycur;
        end
        default: begin
          pick = $urandom_range(0, 3);
          yv   = (pick == 0) ? Q_MAX : (pick == 1) ? Q_MIN : (pick == 2) ? 32'd0 : $urandom;
        end
      endcase
      send_item(OP_APPEND, xnext[31:0], yv, 1'b0, '0);
      xs.insert(xs.size(), xnext);
      xnext += longint'($urandom_range(1, 32'(step_max)));
    end
    nq = $urandom_range(2, 12);
    repeat (nq) begin
      pick = $urandom_range(0, 9);
      if (xs.size() == 0 || pick == 0) begin
        xq = $urandom;
      end else if (pick == 1) begin
        xq = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      end else if (pick <= 3) begin
        xq = clip_q(xs[$urandom_range(0, xs.size() - 1)] +
                    longint'($urandom_range(0, 2)) - 1);
      end else begin
        span = xs[$] - xs[0] + 16;
        lo   = longint'(clip_q(xs[0] - span / 8));
        hi   = longint'(clip_q(xs[$] + span / 8));
        xq   = clip_q(lo + longint'($urandom_range(0, 32'(hi - lo))));
      end
      send_item(OP_QUERY, xq, $urandom, 1'b0, '0);
    end
  endtask

  // result side: random stalls, two long hold-offs so the block backs up
  initial begin
    int unsigned gap;
    int unsigned rx_count;
    rx_count = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 17);
      if (rx_count == 150 || rx_count == 800) gap = LONG_HOLD;
      @(negedge clk_i);
      if (gap != 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
      rx_count++;
    end
  end

  // run watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // main sequence: reset, directed table, random loads and queries, drain
  initial begin
    int r;
    dir_rows = '{
      // empty table, then the unused opcode
      {OP_QUERY,  32'd0,        32'h1234_5678, 1'b1, 32'd0, STS_TOO_FEW},
      {OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, STS_OK},
      // widest possible segment
      {OP_APPEND, Q_MIN,        Q_MIN,         1'b1, 32'd0, STS_OK},
      {OP_QUERY,  Q_MAX,        32'd0,         1'b1, 32'd0, STS_TOO_FEW},
      {OP_APPEND, Q_MIN,        32'd0,         1'b1, 32'd0, STS_NOT_RISING},
      {OP_APPEND, Q_MAX,        Q_MAX,         1'b1, 32'd0, STS_OK},
      {OP_QUERY,  32'd0,        32'd0,         1'b0, 32'd0, STS_OK},
      {OP_QUERY,  Q_MIN,        32'd0,         1'b1, Q_MIN, STS_OK},
      {OP_QUERY,  Q_MAX,        32'd0,         1'b1, Q_MAX, STS_OK},
      {OP_APPEND, Q_MAX,        32'd0,         1'b1, 32'd0, STS_NOT_RISING},
      {OP_CLEAR,  32'd7,        32'd9,         1'b1, 32'd0, STS_OK},
      {OP_QUERY,  32'd5,        32'd0,         1'b1, 32'd0, STS_TOO_FEW},
      // steepest slope, both saturation directions
      {OP_APPEND, 32'd0,        32'd0,         1'b1, 32'd0, STS_OK},
      {OP_APPEND, 32'd1,        Q_MAX,         1'b1, 32'd0, STS_OK},
      {OP_QUERY,  Q_MAX,        32'd0,         1'b1, Q_MAX, STS_OK},
      {OP_QUERY,  Q_MIN,        32'd0,         1'b1, Q_MIN, STS_OK},
      {OP_QUERY,  32'd0,        32'd0,         1'b1, 32'd0, STS_OK},
      // third point, inner segment and extrapolation past the last x
      {OP_APPEND, 32'h0001_0000, Q_MIN,        1'b1, 32'd0, STS_OK},
      {OP_QUERY,  32'h0000_8000, 32'd0,        1'b0, 32'd0, STS_OK},
      {OP_QUERY,  32'h7FFF_0000, 32'd0,        1'b0, 32'd0, STS_OK},
      {OP_QUERY,  32'd1,        32'd0,         1'b0, 32'd0, STS_OK},
      {OP_NOP,    32'd0,        32'd0,         1'b1, 32'd0, STS_OK},
      {OP_APPEND, 32'h0002_0000, Q_MAX,        1'b1, 32'd0, STS_OK},
      {OP_QUERY,  32'h0001_8000, 32'd0,        1'b0, 32'd0, STS_OK},
      {OP_CLEAR,  32'd0,        32'd0,         1'b1, 32'd0, STS_OK}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < $size(dir_rows); r++)
      send_item(dir_rows[r].op, dir_rows[r].xv, dir_rows[r].yv, dir_rows[r].fixed,
                dir_rows[r].want);

    // first load always runs the table past full
    load_and_query(1'b1);
    while (items_sent < ITEM_TARGET) load_and_query(1'b0);

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
